// ===== hdl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab page allocator package
// Shared types, codes and sizes for the allocator engine and its decoder.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int PAGES     = 64;    // managed pages
  localparam int PAGE_W    = 6;     // page index width
  localparam int OBJ_W     = 6;     // object index width inside a page
  localparam int OFS_W     = 12;    // byte offset inside a page
  localparam int CLASSES   = 7;     // size classes 64 .. 4096 bytes
  localparam int LINK_W    = 7;
  localparam int HDR_BYTES = 12;

  localparam logic [LINK_W-1:0] NO_LINK = 7'h7F;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_SMALL = 2'd1,
    KIND_HEAD  = 2'd2,
    KIND_TAIL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_SCAN, S_MK, S_FILL, S_RUN, S_PRD, S_POPGO, S_POP,
    S_FRD, S_LK0, S_LK1, S_PUSH, S_UL0, S_UL1, S_UL2, S_UL3, S_UL4, S_REL,
    S_ADDR, S_OUT
  } state_t;

  // One page table entry.
  typedef struct packed {
    kind_t              kind;
    logic [2:0]         cls;
    logic [LINK_W-1:0]  span;   // run length for a head, owner for a tail
    logic [LINK_W-1:0]  total;
    logic [LINK_W-1:0]  nfree;
    logic [LINK_W-1:0]  prev;
    logic [LINK_W-1:0]  next;
  } pte_t;

  localparam pte_t PTE_CLEAR = '{kind: KIND_FREE, cls: 3'd0, span: 7'd0, total: 7'd0,
                                 nfree: 7'd0, prev: NO_LINK, next: NO_LINK};

  // Decoded request, from the decoder to the engine.
  typedef struct packed {
    logic               is_small;
    logic [2:0]         cls;
    logic               too_big;
    logic [LINK_W-1:0]  span;
    logic               fr_low;
    logic               fr_high;
    logic [PAGE_W-1:0]  fr_page;
    logic [OFS_W-1:0]   fr_inpage;
  } dec_t;

endpackage

// ===== hdl/spa_decode.sv =====
// ----------------------------------------------------------------------------
// Slab page allocator request decoder
// Picks the size class or page span of an allocate request and range-checks
// and splits the offset of a free request.
// ----------------------------------------------------------------------------
module spa_decode import spa_pkg::*; (
  input  logic [32:0] need,
  input  logic [63:0] off,
  input  logic [6:0]  count,
  output dec_t        dec
);

  logic [33:0] span_sum;
  logic [21:0] span_w;
  logic [18:0] hdr;

  always_comb begin
    dec = '0;
    dec.is_small = (need <= 33'd4096);
    dec.cls = 3'(CLASSES - 1);
    // Smallest class that holds the request wins.
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (need <= (33'd64 << c)) begin
        dec.cls = 3'(c);
      end
    end
    span_sum = {1'b0, need} + 34'd4095;
    span_w = span_sum[33:12];
    dec.too_big = (span_w > {15'd0, count});
    dec.span = span_w[6:0];

    dec.fr_low = (off < 64'(HDR_BYTES));
    dec.fr_high = (off[63:19] != '0) || (off[18:0] >= {count, 12'd0});
    hdr = off[18:0] - 19'(HDR_BYTES);
    dec.fr_page = hdr[17:12];
    dec.fr_inpage = hdr[11:0];
  end

endmodule

// ===== hdl/slab_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Slab page allocator
// Allocates and frees objects of seven power-of-two size classes from slab
// pages, and page runs for larger requests, over a page table memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  in_       request    in_valid / in_ready           func, request_size, free_address
//  out_      result     out_valid / out_ready         user_address, status
//  cfg_      register   APB write, cfg_pready high    heap_base, usable_slabs
//
// One request is worked on at a time. The page search walks the page
// table memory one page per cycle, a new slab fills its free stack one
// object per cycle, and a run is written or released one page per cycle.
// After reset a pass over every page clears the page table while in_ready
// stays low. A waiting result does not block the next request from being
// accepted; it only holds the engine before it delivers.
module slab_page_allocator_top import spa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_request_size,
  input  logic [63:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_user_address,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [63:0] base_r;
  logic [6:0]  usable_r;
  logic [6:0]  count;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[3] ? {57'd0, usable_r} : base_r;
  assign count = (usable_r > 7'(PAGES)) ? 7'(PAGES) : usable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      usable_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[3]) begin
        usable_r <= cfg_pwdata[6:0];
      end else begin
        base_r <= cfg_pwdata;
      end
    end
  end

  // Memories.
  pte_t                      pt_mem [PAGES];
  logic [OBJ_W-1:0]          stk_mem [PAGES * PAGES];
  logic [PAGES-1:0]          live_mem [PAGES];

  logic                      pt_we;
  logic [PAGE_W-1:0]         pt_wa, pt_ra;
  pte_t                      pt_wd, pt_rd;
  logic                      stk_we;
  logic [PAGE_W+OBJ_W-1:0]   stk_wa, stk_ra;
  logic [OBJ_W-1:0]          stk_wd, stk_rd;
  logic                      live_we;
  logic [PAGE_W-1:0]         live_wa, live_ra;
  logic [PAGES-1:0]          live_wd, live_rd;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_rd <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    live_rd <= live_mem[live_ra];
  end

  // Engine registers.
  state_t             state_r, state_nxt;
  logic               func_r, func_nxt;
  logic               zero_r, zero_nxt;
  logic               azero_r, azero_nxt;
  logic               big_r, big_nxt;
  logic [32:0]        need_r, need_nxt;
  logic [63:0]        off_r, off_nxt;
  logic [PAGE_W-1:0]  p_r, p_nxt;
  logic [PAGE_W-1:0]  start_r, start_nxt;
  logic [PAGE_W-1:0]  clr_r, clr_nxt;
  logic [2:0]         c_r, c_nxt;
  logic [6:0]         span_r, span_nxt;
  logic [6:0]         len_r, len_nxt;
  logic [6:0]         chk_r, chk_nxt;
  logic [6:0]         k_r, k_nxt;
  logic [6:0]         nb_r, nb_nxt;
  logic [OBJ_W-1:0]   obj_r, obj_nxt;
  logic [OFS_W-1:0]   inpage_r, inpage_nxt;
  logic [17:0]        ofs_r, ofs_nxt;
  pte_t               cur_r, cur_nxt;
  logic [LINK_W-1:0]  head_r [CLASSES];
  logic [LINK_W-1:0]  head_nxt [CLASSES];
  logic [63:0]        res_addr_r, res_addr_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_addr_r, out_addr_nxt;
  status_t            out_st_r, out_st_nxt;

  dec_t dec;

  spa_decode u_dec (
    .need  (need_r),
    .off   (off_r),
    .count (count),
    .dec   (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLASSES; i++) begin
        head_r[i] <= NO_LINK;
      end
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < CLASSES; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    zero_r <= zero_nxt;
    azero_r <= azero_nxt;
    big_r <= big_nxt;
    need_r <= need_nxt;
    off_r <= off_nxt;
    p_r <= p_nxt;
    start_r <= start_nxt;
    c_r <= c_nxt;
    span_r <= span_nxt;
    len_r <= len_nxt;
    chk_r <= chk_nxt;
    k_r <= k_nxt;
    nb_r <= nb_nxt;
    obj_r <= obj_nxt;
    inpage_r <= inpage_nxt;
    ofs_r <= ofs_nxt;
    cur_r <= cur_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r <= out_st_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_user_address = out_addr_r;
  assign out_status = out_st_r;

  pte_t              w;
  logic [PAGE_W-1:0] st;
  logic [2:0]        c_eff;
  logic [OFS_W-1:0]  msk;
  logic [OBJ_W-1:0]  objv;
  logic [LINK_W-1:0] hd;
  logic [6:0]        nfp1;

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    zero_nxt = zero_r;
    azero_nxt = azero_r;
    big_nxt = big_r;
    need_nxt = need_r;
    off_nxt = off_r;
    p_nxt = p_r;
    start_nxt = start_r;
    clr_nxt = clr_r;
    c_nxt = c_r;
    span_nxt = span_r;
    len_nxt = len_r;
    chk_nxt = chk_r;
    k_nxt = k_r;
    nb_nxt = nb_r;
    obj_nxt = obj_r;
    inpage_nxt = inpage_r;
    ofs_nxt = ofs_r;
    cur_nxt = cur_r;
    head_nxt = head_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt = out_addr_r;
    out_st_nxt = out_st_r;

    pt_we = 1'b0;
    pt_wa = p_r;
    pt_wd = PTE_CLEAR;
    pt_ra = p_r;
    stk_we = 1'b0;
    stk_wa = {p_r, k_r[OBJ_W-1:0]};
    stk_wd = k_r[OBJ_W-1:0];
    stk_ra = {p_r, k_r[OBJ_W-1:0]};
    live_we = 1'b0;
    live_wa = p_r;
    live_wd = '0;
    live_ra = p_r;

    w = pt_rd;
    st = start_r;
    c_eff = c_r;
    msk = '0;
    objv = obj_r;
    hd = head_r[c_r];
    nfp1 = cur_r.nfree + 7'd1;

    case (state_r)
      S_CLR: begin
        pt_we = 1'b1;
        pt_wa = clr_r;
        clr_nxt = clr_r + 6'd1;
        if (clr_r == 6'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          zero_nxt = (in_request_size == '0);
          azero_nxt = (in_free_address == '0);
          need_nxt = {1'b0, in_request_size} + 33'(HDR_BYTES);
          off_nxt = in_free_address - base_r;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_addr_nxt = '0;
        chk_nxt = '0;
        len_nxt = '0;
        if (!func_r) begin
          big_nxt = !dec.is_small;
          if (zero_r) begin
            res_st_nxt = ST_ZERO;
            state_nxt = S_OUT;
          end else if (count == '0) begin
            res_st_nxt = ST_NOSPACE;
            state_nxt = S_OUT;
          end else if (dec.is_small) begin
            c_nxt = dec.cls;
            hd = head_r[dec.cls];
            if (hd == NO_LINK) begin
              span_nxt = 7'd1;
              pt_ra = '0;
              state_nxt = S_SCAN;
            end else if (hd[LINK_W-1]) begin
              res_st_nxt = ST_NOSPACE;
              state_nxt = S_OUT;
            end else begin
              p_nxt = hd[PAGE_W-1:0];
              pt_ra = hd[PAGE_W-1:0];
              state_nxt = S_PRD;
            end
          end else if (dec.too_big) begin
            res_st_nxt = ST_NOSPACE;
            state_nxt = S_OUT;
          end else begin
            span_nxt = dec.span;
            pt_ra = '0;
            state_nxt = S_SCAN;
          end
        end else begin
          if (azero_r || (count == '0) || dec.fr_low || dec.fr_high) begin
            res_st_nxt = ST_REJECT;
            state_nxt = S_OUT;
          end else begin
            p_nxt = dec.fr_page;
            inpage_nxt = dec.fr_inpage;
            pt_ra = dec.fr_page;
            live_ra = dec.fr_page;
            state_nxt = S_FRD;
          end
        end
      end

      // First-fit search; the data of page chk_r arrives while the next
      // page is being read.
      S_SCAN: begin
        pt_ra = chk_r[PAGE_W-1:0] + 6'd1;
        if (chk_r >= count) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt = S_OUT;
        end else begin
          chk_nxt = chk_r + 7'd1;
          if (pt_rd.kind != KIND_FREE) begin
            len_nxt = '0;
          end else begin
            st = (len_r == '0) ? chk_r[PAGE_W-1:0] : start_r;
            start_nxt = st;
            len_nxt = len_r + 7'd1;
            if ((len_r + 7'd1) == span_r) begin
              k_nxt = '0;
              if (big_r) begin
                state_nxt = S_RUN;
              end else begin
                p_nxt = st;
                state_nxt = S_MK;
              end
            end
          end
        end
      end

      S_MK: begin
        w = PTE_CLEAR;
        w.kind = KIND_SMALL;
        w.cls = c_r;
        w.span = 7'd1;
        w.total = 7'd64 >> c_r;
        w.nfree = 7'd64 >> c_r;
        pt_we = 1'b1;
        pt_wd = w;
        cur_nxt = w;
        head_nxt[c_r] = {1'b0, p_r};
        live_we = 1'b1;
        live_wd = '0;
        k_nxt = '0;
        state_nxt = S_FILL;
      end

      S_FILL: begin
        stk_we = 1'b1;
        k_nxt = k_r + 7'd1;
        if (k_r == (cur_r.total - 7'd1)) begin
          state_nxt = S_POPGO;
        end
      end

      S_PRD: begin
        if ((pt_rd.kind != KIND_SMALL) || (pt_rd.nfree == '0)) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt = S_OUT;
        end else begin
          cur_nxt = pt_rd;
          state_nxt = S_POPGO;
        end
      end

      S_POPGO: begin
        cur_nxt.nfree = cur_r.nfree - 7'd1;
        stk_ra = {p_r, 6'(cur_r.nfree - 7'd1)};
        live_ra = p_r;
        state_nxt = S_POP;
      end

      S_POP: begin
        objv = stk_rd;
        obj_nxt = objv;
        live_we = 1'b1;
        live_wd = live_rd | (64'd1 << objv);
        ofs_nxt = {p_r, 12'({6'd0, objv} << (6 + c_r))} + 18'(HDR_BYTES);
        if (cur_r.nfree == '0) begin
          state_nxt = S_UL0;
        end else begin
          pt_we = 1'b1;
          pt_wd = cur_r;
          state_nxt = S_ADDR;
        end
      end

      S_RUN: begin
        w = PTE_CLEAR;
        if (k_r == '0) begin
          w.kind = KIND_HEAD;
          w.span = span_r;
          w.total = 7'd1;
        end else begin
          w.kind = KIND_TAIL;
          w.span = {1'b0, start_r};
        end
        pt_we = 1'b1;
        pt_wa = start_r + k_r[PAGE_W-1:0];
        pt_wd = w;
        k_nxt = k_r + 7'd1;
        if (k_r == (span_r - 7'd1)) begin
          ofs_nxt = {start_r, 12'(HDR_BYTES)};
          state_nxt = S_ADDR;
        end
      end

      S_FRD: begin
        res_addr_nxt = '0;
        if (pt_rd.kind == KIND_HEAD) begin
          if ((inpage_r != '0) || (pt_rd.span == '0) ||
              (({1'b0, 1'b0, p_r} + {1'b0, pt_rd.span}) > {1'b0, count})) begin
            res_st_nxt = ST_REJECT;
            state_nxt = S_OUT;
          end else begin
            span_nxt = pt_rd.span;
            k_nxt = '0;
            state_nxt = S_REL;
          end
        end else if (pt_rd.kind == KIND_SMALL) begin
          // Class code seven folds back onto class zero.
          c_eff = (pt_rd.cls == 3'd7) ? 3'd0 : pt_rd.cls;
          msk = ~(12'hFFF << (6 + c_eff));
          objv = 6'(inpage_r >> (6 + c_eff));
          if (((inpage_r & msk) != '0) || !live_rd[objv] ||
              (pt_rd.nfree >= pt_rd.total)) begin
            res_st_nxt = ST_REJECT;
            state_nxt = S_OUT;
          end else begin
            cur_nxt = pt_rd;
            obj_nxt = objv;
            c_nxt = c_eff;
            live_we = 1'b1;
            live_wd = live_rd & ~(64'd1 << objv);
            state_nxt = (pt_rd.nfree == '0) ? S_LK0 : S_PUSH;
          end
        end else begin
          res_st_nxt = ST_REJECT;
          state_nxt = S_OUT;
        end
      end

      // A full slab that gets an object back joins the front of its list.
      S_LK0: begin
        if ((cur_r.prev != NO_LINK) || (cur_r.next != NO_LINK) || (hd == {1'b0, p_r})) begin
          state_nxt = S_PUSH;
        end else begin
          cur_nxt.next = hd;
          cur_nxt.prev = NO_LINK;
          head_nxt[c_r] = {1'b0, p_r};
          nb_nxt = hd;
          if (!hd[LINK_W-1]) begin
            pt_ra = hd[PAGE_W-1:0];
            state_nxt = S_LK1;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end

      S_LK1: begin
        w.prev = {1'b0, p_r};
        pt_we = 1'b1;
        pt_wa = nb_r[PAGE_W-1:0];
        pt_wd = w;
        state_nxt = S_PUSH;
      end

      S_PUSH: begin
        stk_we = 1'b1;
        stk_wa = {p_r, cur_r.nfree[OBJ_W-1:0]};
        stk_wd = obj_r;
        cur_nxt.nfree = nfp1;
        if (nfp1 == cur_r.total) begin
          state_nxt = S_UL0;
        end else begin
          w = cur_r;
          w.nfree = nfp1;
          pt_we = 1'b1;
          pt_wd = w;
          res_addr_nxt = '0;
          res_st_nxt = ST_OK;
          state_nxt = S_OUT;
        end
      end

      S_UL0: begin
        if (!cur_r.prev[LINK_W-1]) begin
          pt_ra = cur_r.prev[PAGE_W-1:0];
          state_nxt = S_UL1;
        end else begin
          if (hd == {1'b0, p_r}) begin
            head_nxt[c_r] = cur_r.next;
          end
          state_nxt = S_UL2;
        end
      end

      S_UL1: begin
        w.next = cur_r.next;
        pt_we = 1'b1;
        pt_wa = cur_r.prev[PAGE_W-1:0];
        pt_wd = w;
        state_nxt = S_UL2;
      end

      S_UL2: begin
        if (!cur_r.next[LINK_W-1]) begin
          pt_ra = cur_r.next[PAGE_W-1:0];
          state_nxt = S_UL3;
        end else begin
          state_nxt = S_UL4;
        end
      end

      S_UL3: begin
        w.prev = cur_r.prev;
        pt_we = 1'b1;
        pt_wa = cur_r.next[PAGE_W-1:0];
        pt_wd = w;
        state_nxt = S_UL4;
      end

      // An emptied slab is released; a slab that ran out stays off the list.
      S_UL4: begin
        pt_we = 1'b1;
        if (!func_r) begin
          w = cur_r;
          w.prev = NO_LINK;
          w.next = NO_LINK;
          pt_wd = w;
          state_nxt = S_ADDR;
        end else begin
          pt_wd = PTE_CLEAR;
          res_addr_nxt = '0;
          res_st_nxt = ST_OK;
          state_nxt = S_OUT;
        end
      end

      S_REL: begin
        pt_we = 1'b1;
        pt_wa = p_r + k_r[PAGE_W-1:0];
        pt_wd = PTE_CLEAR;
        k_nxt = k_r + 7'd1;
        if (k_r == (span_r - 7'd1)) begin
          res_st_nxt = ST_OK;
          state_nxt = S_OUT;
        end
      end

      S_ADDR: begin
        res_addr_nxt = base_r + {46'd0, ofs_r};
        res_st_nxt = ST_OK;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt = res_addr_r;
          out_st_nxt = res_st_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Checks.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("request accepted during page table clear");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_user_address == '0))
    else $error("failed result carries an address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in work");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (chk_r <= 7'(PAGES)))
    else $error("page search ran past the page table");

endmodule
